/* rtl/circular_deque_engine_assert.svh */
// Assertion helpers; expect clk and rst in scope of the including module.
`ifndef CIRCULAR_DEQUE_ENGINE_ASSERT_SVH
`define CIRCULAR_DEQUE_ENGINE_ASSERT_SVH

// Property that holds in the same cycle as its trigger.
`define CDE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deque engine check failed");

// Property that holds in the cycle after its trigger.
`define CDE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deque engine check failed");

`endif

/* rtl/cde_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cde_pkg;

  localparam int CDE_DEPTH = 16;

  localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [2:0] MODE_PUSH_REAR  = 3'd1;
  localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [2:0] MODE_POP_REAR   = 3'd3;
  localparam logic [2:0] MODE_PEEK       = 3'd4;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] item;
  } in_word_t;

  typedef struct packed {
    logic [7:0] popped_value;
    logic [7:0] front_value;
    logic [7:0] rear_value;
    logic       empty_flag;
    logic       is_full;
    logic       op_error;
  } out_word_t;

endpackage

`default_nettype wire

/* rtl/cde_core.sv */
`timescale 1ns / 1ps
`default_nettype none

module cde_core import cde_pkg::*; #(
  parameter int DEPTH = CDE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      res_valid,
  input  logic      res_stall,
  output out_word_t res_word
);

  `include "circular_deque_engine_assert.svh"

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_FIN  = 2'b10
  } state_t;

  function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
    return (i == IDX_LAST) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_LAST : i - 1'b1;
  endfunction

  state_t state, state_next;
  logic [IDX_W-1:0] head, head_next;
  logic [IDX_W-1:0] tail, tail_next;

  // cached copies of the first and last entries
  logic [7:0] front_c, front_c_next;
  logic [7:0] rear_c, rear_c_next;

  logic [7:0] pend_popped, popped_c;
  logic       pend_err, err_c;
  logic       rd_front, rd_rear, rdf_c, rdr_c;

  logic [7:0]       mem [DEPTH];
  logic [7:0]       rdata;
  logic             we, re;
  logic [IDX_W-1:0] waddr, raddr;
  logic [7:0]       wdata;

  logic acc, cur_empty, cur_full;
  logic empty_now;
  logic [7:0] front_v, rear_v;

  assign acc       = (state == ST_IDLE) && in_valid;
  assign in_stall  = (state != ST_IDLE);
  assign cur_empty = (head == tail);
  assign cur_full  = (idx_next(tail) == head);

  always_comb begin
    head_next    = head;
    tail_next    = tail;
    front_c_next = front_c;
    rear_c_next  = rear_c;
    we           = 1'b0;
    waddr        = head;
    wdata        = in_word.item;
    re           = 1'b0;
    raddr        = head;
    popped_c     = '0;
    err_c        = 1'b0;
    rdf_c        = 1'b0;
    rdr_c        = 1'b0;
    state_next   = state;

    if (state == ST_FIN) begin
      if (rd_front) front_c_next = rdata;
      if (rd_rear)  rear_c_next  = rdata;
      if (!res_stall) state_next = ST_IDLE;
    end

    if (acc) begin
      state_next = ST_FIN;
      case (in_word.mode)
        MODE_PUSH_FRONT: begin
          if (cur_full) begin
            err_c = 1'b1;
          end else begin
            we           = 1'b1;
            waddr        = head;
            head_next    = idx_prev(head);
            front_c_next = in_word.item;
            if (cur_empty) rear_c_next = in_word.item;
          end
        end
        MODE_PUSH_REAR: begin
          if (cur_full) begin
            err_c = 1'b1;
          end else begin
            we          = 1'b1;
            waddr       = idx_next(tail);
            tail_next   = idx_next(tail);
            rear_c_next = in_word.item;
            if (cur_empty) front_c_next = in_word.item;
          end
        end
        MODE_POP_FRONT: begin
          if (cur_empty) begin
            err_c = 1'b1;
          end else begin
            head_next = idx_next(head);
            popped_c  = front_c;
            // fetch the entry that becomes the new front
            re        = 1'b1;
            raddr     = idx_next(idx_next(head));
            rdf_c     = 1'b1;
          end
        end
        MODE_POP_REAR: begin
          if (cur_empty) begin
            err_c = 1'b1;
          end else begin
            tail_next = idx_prev(tail);
            popped_c  = rear_c;
            re        = 1'b1;
            raddr     = idx_prev(tail);
            rdr_c     = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      head     <= '0;
      tail     <= '0;
      rd_front <= 1'b0;
      rd_rear  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      if (acc) begin
        rd_front <= rdf_c;
        rd_rear  <= rdr_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    front_c <= front_c_next;
    rear_c  <= rear_c_next;
    if (acc) begin
      pend_popped <= popped_c;
      pend_err    <= err_c;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  assign empty_now = (head == tail);
  assign front_v   = rd_front ? rdata : front_c;
  assign rear_v    = rd_rear  ? rdata : rear_c;

  assign res_valid             = (state == ST_FIN);
  assign res_word.popped_value = pend_popped;
  assign res_word.front_value  = empty_now ? '0 : front_v;
  assign res_word.rear_value   = empty_now ? '0 : rear_v;
  assign res_word.empty_flag   = empty_now;
  assign res_word.is_full      = (idx_next(tail) == head);
  assign res_word.op_error     = pend_err;

  `CDE_ASSERT_NEXT(a_err_keeps_indices, acc && err_c, head == $past(head) && tail == $past(tail))
  `CDE_ASSERT_NOW(a_fin_no_mem_access, state == ST_FIN, !we && !re)
  `CDE_ASSERT_NOW(a_single_fetch, state == ST_FIN, !(rd_front && rd_rear))
  `CDE_ASSERT_NOW(a_not_full_and_empty, 1'b1, !(cur_empty && cur_full))

endmodule

`default_nettype wire

/* rtl/cde_out_reg.sv */
`timescale 1ns / 1ps
`default_nettype none

module cde_out_reg import cde_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      res_valid,
  output logic      res_stall,
  input  out_word_t res_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic load;

  assign res_stall = out_valid && out_stall;
  assign load      = res_valid && !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // hold the word while the receiver stalls
  always_ff @(posedge clk) begin
    if (load) out_word <= res_word;
  end

endmodule

`default_nettype wire

/* rtl/circular_deque_engine.sv */
// Byte deque on a ring of DEPTH slots, holding at most DEPTH-1 entries.
// Input channel: in_valid / in_stall carry one word (mode, item) per
// operation: push front, push rear, pop front, pop rear or peek.
// Output channel: out_valid / out_stall carry one result word per
// operation: popped byte, first and last entries, empty, full and error.
// A push when full or a pop when empty flags op_error and changes nothing.
// A taken input word moves the core to its finish state, whose result is
// then loaded into the output register, which raises out_valid.
// The core takes no new word until it leaves the finish state; there the
// slot memory's read refills the cached front or rear entry after a pop,
// and every operation takes the same path.
// The front and rear entries are cached in registers, so each operation
// touches the slot memory at most once.
// Reset empties the deque at once; no memory sweep is needed.
// A stalled result sits in the output register; the engine can still take
// one more word and then holds in_stall high until the register frees up.
`timescale 1ns / 1ps
`default_nettype none

module circular_deque_engine import cde_pkg::*; #(
  parameter int DEPTH = CDE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic      res_valid;
  logic      res_stall;
  out_word_t res_word;

  cde_core #(
    .DEPTH(DEPTH)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_word (res_word)
  );

  cde_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_word (res_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

endmodule

`default_nettype wire

/* verif/tb_circular_deque_engine.sv */
`timescale 1ns / 1ps

module tb_circular_deque_engine;
  import cde_pkg::*;

  localparam int DEPTH = CDE_DEPTH;
  localparam int RANDOM_OPS = 1900;
  // Codes with no operation behind them; the deque treats them as a peek.
  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  class deque_scoreboard;
    logic [7:0] slots [DEPTH];
    int unsigned head_idx;
    int unsigned tail_idx;
    out_word_t awaited [$];
    int fails;
    int pushes;
    int pops;
    int peeks;
    int rejected;
    int full_hits;

    function new();
      foreach (slots[i]) slots[i] = '0;
      head_idx = 0;
      tail_idx = 0;
      fails = 0;
      pushes = 0;
      pops = 0;
      peeks = 0;
      rejected = 0;
      full_hits = 0;
    endfunction

    function out_word_t apply_op(in_word_t w);
      out_word_t r;
      bit was_empty;
      bit was_full;
      r = '0;
      was_empty = (head_idx == tail_idx);
      was_full = (((tail_idx + 1) % DEPTH) == head_idx);
      case (w.mode)
        MODE_PUSH_FRONT: begin
          pushes++;
          if (was_full) begin
            r.op_error = 1'b1;
          end else begin
            slots[head_idx] = w.item;
            head_idx = (head_idx + DEPTH - 1) % DEPTH;
          end
        end
        MODE_PUSH_REAR: begin
          pushes++;
          if (was_full) begin
            r.op_error = 1'b1;
          end else begin
            tail_idx = (tail_idx + 1) % DEPTH;
            slots[tail_idx] = w.item;
          end
        end
        MODE_POP_FRONT: begin
          pops++;
          if (was_empty) begin
            r.op_error = 1'b1;
          end else begin
            head_idx = (head_idx + 1) % DEPTH;
            r.popped_value = slots[head_idx];
          end
        end
        MODE_POP_REAR: begin
          pops++;
          if (was_empty) begin
            r.op_error = 1'b1;
          end else begin
            r.popped_value = slots[tail_idx];
            tail_idx = (tail_idx + DEPTH - 1) % DEPTH;
          end
        end
        default: begin
          peeks++;
        end
      endcase
      r.empty_flag = (head_idx == tail_idx);
      r.is_full = (((tail_idx + 1) % DEPTH) == head_idx);
      if (!r.empty_flag) begin
        r.front_value = slots[(head_idx + 1) % DEPTH];
        r.rear_value = slots[tail_idx];
      end
      if (r.op_error) rejected++;
      if (r.is_full && !was_full) full_hits++;
      return r;
    endfunction

    function void take_op(in_word_t w);
      awaited.push_back(apply_op(w));
    endfunction

    function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        fails++;
      end
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (awaited.size() == 0) begin
        $error("result word %h arrived with nothing outstanding", got);
        fails++;
        return;
      end
      want = awaited.pop_front();
      cmp_field("popped_value", want.popped_value, got.popped_value);
      cmp_field("front_value", want.front_value, got.front_value);
      cmp_field("rear_value", want.rear_value, got.rear_value);
      cmp_field("empty_flag", 8'(want.empty_flag), 8'(got.empty_flag));
      cmp_field("is_full", 8'(want.is_full), 8'(got.is_full));
      cmp_field("op_error", 8'(want.op_error), 8'(got.op_error));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;
  bit steady = 1'b0;
  deque_scoreboard sb;

  circular_deque_engine dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word(out_word)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_word);
  end

  initial begin
    forever begin
      @(negedge clk);
      out_stall = !steady && ($urandom_range(99) < 37);
    end
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [2:0] pick_mode(int push_pct, int pop_pct);
    int r;
    bit rear_side;
    r = $urandom_range(99);
    rear_side = 1'($urandom_range(1));
    if (r < push_pct) return rear_side ? MODE_PUSH_REAR : MODE_PUSH_FRONT;
    if (r < push_pct + pop_pct) return rear_side ? MODE_POP_REAR : MODE_POP_FRONT;
    if (r[0]) return MODE_PEEK;
    return 3'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
  endfunction

  task automatic send_op(logic [2:0] op_mode, logic [7:0] op_item);
    while (!steady && $urandom_range(99) < 37) begin
      @(negedge clk);
      in_valid = 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_word.mode = op_mode;
    in_word.item = op_item;
    do @(posedge clk); while (in_stall);
    sb.take_op(in_word);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  initial begin
    int sent;
    int burst_len;
    int push_pct;
    int pop_pct;
    int pick;
    int k;
    sb = new();
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // underflow on both ends, then build up and tear down from both ends
    send_op(MODE_POP_FRONT, 8'hFF);
    send_op(MODE_POP_REAR, 8'h00);
    send_op(MODE_PEEK, 8'hFF);
    send_op(MODE_SPARE_HI, 8'h00);
    send_op(MODE_PUSH_FRONT, 8'h00);
    send_op(MODE_PUSH_REAR, 8'hFF);
    send_op(MODE_PUSH_FRONT, 8'hAA);
    send_op(MODE_PUSH_REAR, 8'h55);
    send_op(MODE_SPARE_LO, 8'h12);
    send_op(MODE_PEEK, 8'h34);
    send_op(MODE_POP_FRONT, 8'h00);
    send_op(MODE_POP_REAR, 8'h00);
    send_op(MODE_POP_REAR, 8'hFF);
    send_op(MODE_POP_FRONT, 8'hFF);
    send_op(MODE_POP_REAR, 8'h00);
    send_op(MODE_PUSH_REAR, 8'h80);
    send_op(MODE_POP_FRONT, 8'h7F);

    // bursts biased toward filling or emptying keep hitting both limits
    sent = 0;
    while (sent < RANDOM_OPS) begin
      pick = $urandom_range(9);
      if (pick < 4) begin
        push_pct = 80;
        pop_pct = 15;
      end else if (pick < 8) begin
        push_pct = 15;
        pop_pct = 80;
      end else if (pick == 8) begin
        push_pct = 45;
        pop_pct = 45;
      end else begin
        push_pct = 20;
        pop_pct = 20;
      end
      burst_len = $urandom_range(40, 8);
      for (k = 0; k < burst_len; k++) begin
        steady = (sent >= 700 && sent < 1000);
        if (sent == 450 || sent == 1400) drain();
        send_op(pick_mode(push_pct, pop_pct), rand_byte());
        sent++;
      end
    end
    steady = 1'b0;

    drain();
    repeat (8) @(posedge clk);
    $display("deque run: %0d pushes, %0d pops, %0d peeks or spare codes",
             sb.pushes, sb.pops, sb.peeks);
    $display("%0d rejected for overflow or underflow, deque filled %0d times",
             sb.rejected, sb.full_hits);
    if (sb.fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
